>>> rtl/palt_pkg.sv
// Shared types, constants and table generators for the pressure to altitude core.
// Used by palt_log2, palt_exp2 and pressure_to_altitude_isa_core; no dependencies.
`default_nettype none

package palt_pkg;

   localparam int PRES_W = 24;
   localparam int ALT_W = 27;
   localparam int LOG_W = 29;
   localparam int ARG_W = 27;
   localparam int POW_W = 29;
   localparam int LOG_TAB_W = 25;
   localparam int EXP_TAB_W = 26;
   localparam int ONE_Q24 = 16777216;

   localparam logic [1:0] LAYER_TROPO = 2'd0;
   localparam logic [1:0] LAYER_LOWER = 2'd1;
   localparam logic [1:0] LAYER_UPPER = 2'd2;

   localparam logic [PRES_W-1:0] P_SEA_Q6 = 24'd6484800;
   localparam logic [PRES_W-1:0] P_TROPO_Q6 = 24'd1448320;
   localparam logic [PRES_W-1:0] P_MID_Q6 = 24'd350400;

   localparam logic signed [28:0] EXP_TROPO_Q30 = 29'sd204297033;
   localparam logic signed [28:0] EXP_UPPER_NEG_Q30 = -29'sd31430313;
   localparam logic signed [28:0] K_LOWER_Q8 = 29'sd1125312;
   localparam logic signed [26:0] K_TROPO_Q8 = 27'sd11348677;
   localparam logic signed [26:0] K_UPPER_Q8 = 27'sd55462400;
   localparam logic signed [ALT_W-1:0] BASE_LOWER_Q8 = 27'sd2816000;
   localparam logic signed [ALT_W-1:0] BASE_UPPER_Q8 = 27'sd5120000;
   localparam logic signed [ALT_W-1:0] ALT_MAX = 27'sh3FFFFFF;
   localparam logic signed [ALT_W-1:0] ALT_MIN = 27'sh4000000;

   // Sideband that travels with every request through the pipeline.
   typedef struct packed {
      logic valid;
      logic [1:0] layer;
      logic zero;
      logic signed [ALT_W-1:0] alt;
   } tag_type;

   // Next value of a tag register: the valid bit is dropped while reset is high.
   function automatic tag_type gate_tag(input tag_type t, input logic clear);
      tag_type g;
      g = t;
      g.valid = t.valid && !clear;
      return g;
   endfunction

   // log2(1 + i/2^abits) in Q24, found by repeated squaring.
   function automatic logic [LOG_TAB_W-1:0] log_entry(input int abits, input int i);
      longint unsigned x;
      longint unsigned acc;
      if (i >= (1 << abits)) return LOG_TAB_W'(ONE_Q24);
      x = 64'((1 << abits) + i) << (30 - abits);
      acc = 64'd0;
      for (int b = 0; b < 25; b++) begin
         x = (x * x) >> 30;
         acc = acc << 1;
         if (x >= (64'd2 << 30)) begin
            acc = acc | 64'd1;
            x = x >> 1;
         end
      end
      return LOG_TAB_W'((acc + 64'd1) >> 1);
   endfunction

   function automatic longint unsigned isqrt64(input longint unsigned v_in);
      longint unsigned v;
      longint unsigned res;
      longint unsigned bt;
      v = v_in;
      res = 64'd0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 64'd0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // 2^(i/2^abits) in Q24, built as a product of repeated square roots of two.
   function automatic logic [EXP_TAB_W-1:0] exp_entry(input int abits, input int i);
      longint unsigned s;
      longint unsigned p;
      if (i >= (1 << abits)) return EXP_TAB_W'(2 * ONE_Q24);
      s = 64'd2 << 30;
      p = 64'd1 << 30;
      for (int b = 1; b <= abits; b++) begin
         s = isqrt64(s << 30);
         if (((i >> (abits - b)) & 1) != 0) p = (p * s) >> 30;
      end
      return EXP_TAB_W'((p + 64'd32) >> 6);
   endfunction

   // Interpolated log2 of a constant, bit for bit what the pipeline produces.
   function automatic logic [31:0] ref_log(input int abits, input logic [PRES_W-1:0] v);
      int k;
      int sh;
      int idx;
      logic [PRES_W-1:0] norm;
      logic [22:0] frac;
      longint unsigned r;
      longint unsigned lo;
      longint unsigned hi;
      k = 0;
      for (int j = 0; j < PRES_W; j++) if (v[j]) k = j;
      norm = v << (23 - k);
      frac = norm[22:0];
      sh = 23 - abits;
      idx = int'(frac >> sh);
      r = 64'(frac) & ((64'd1 << sh) - 64'd1);
      lo = 64'(log_entry(abits, idx));
      hi = 64'(log_entry(abits, idx + 1));
      lo = lo + (((hi - lo) * r) >> sh);
      return 32'(64'(k) << 24) + 32'(lo);
   endfunction

endpackage

`default_nettype wire

>>> rtl/pressure_to_altitude_isa_core.sv
// Top level of the three-layer standard atmosphere pressure to altitude converter.
// Depends on palt_pkg, palt_log2 and palt_exp2.
//
// Usage: drive req_pressure_q6 (unsigned, 1/64 Pa) and raise start; the request is
// taken at each rising edge where start is high and busy is low. busy is high only
// while reset is asserted, so outside reset one request can be taken every cycle.
// Each result appears on rsp_altitude_q8 (signed, 1/256 m), rsp_layer and
// rsp_saturated for exactly one cycle with rsp_valid high. Results leave in request
// order. Each request passes through the log2 unit (normalize, lookup, multiply,
// sum), the coefficient multiply and floor, the exp2 unit (lookup, multiply, shift)
// and the final scaling multiply and rounding. Throughput is one request per clock.
// The receiver cannot hold a result off; none is ever waiting, since the pipeline
// never stops. Synchronous reset clears every valid bit, so requests in flight at
// reset are dropped. A pressure of zero gives the largest altitude with
// rsp_saturated high and the upper stratosphere layer code.
`default_nettype none

module pressure_to_altitude_isa_core #(
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [palt_pkg::PRES_W-1:0]         req_pressure_q6,
   output logic                                rsp_valid,
   output logic signed [palt_pkg::ALT_W-1:0]   rsp_altitude_q8,
   output logic [1:0]                          rsp_layer,
   output logic                                rsp_saturated
);

   localparam int LATENCY = 14;
   localparam logic signed [30:0] REF_SEA =
      31'(palt_pkg::ref_log(TABLE_ADDR_BITS, palt_pkg::P_SEA_Q6));
   localparam logic signed [30:0] REF_TROPO =
      31'(palt_pkg::ref_log(TABLE_ADDR_BITS, palt_pkg::P_TROPO_Q6));
   localparam logic signed [30:0] REF_MID =
      31'(palt_pkg::ref_log(TABLE_ADDR_BITS, palt_pkg::P_MID_Q6));
   localparam logic signed [29:0] Y_LO = -30'sd67108864;
   localparam logic signed [29:0] Y_HI = 30'sd67108863;
   localparam logic signed [29:0] ONE_T = 30'sd16777216;

   logic valid0_ff;
   logic [palt_pkg::PRES_W-1:0] pres0_ff;
   palt_pkg::tag_type tag0, tag_l, tag_e;
   palt_pkg::tag_type tagd_ff, tagm_ff, tagy_in, tagy_ff, tags_ff, tagk_ff;
   logic [palt_pkg::LOG_W-1:0] log_l;
   logic [palt_pkg::POW_W-1:0] pow_e;
   logic signed [30:0] ref_sel, d_in, d_ff;
   logic signed [28:0] coef_m;
   logic signed [59:0] prodm_ff, round_m;
   logic signed [29:0] y, yc;
   logic signed [35:0] h_lower;
   logic [palt_pkg::ARG_W-1:0] argy_in, argy_ff;
   logic signed [29:0] t_in, t_ff;
   logic signed [26:0] coef_k;
   logic signed [56:0] prodk_ff, round_k;
   logic signed [33:0] h_out;
   logic signed [palt_pkg::ALT_W-1:0] alt_in;
   logic rsp_valid_ff, rsp_saturated_ff;
   logic signed [palt_pkg::ALT_W-1:0] rsp_altitude_ff;
   logic [1:0] rsp_layer_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      pres0_ff <= req_pressure_q6;
      valid0_ff <= start && !busy;
   end

   always_comb begin
      tag0.valid = valid0_ff;
      tag0.zero = (pres0_ff == '0);
      tag0.alt = '0;
      if (pres0_ff > palt_pkg::P_TROPO_Q6) begin
         tag0.layer = palt_pkg::LAYER_TROPO;
      end else if (pres0_ff > palt_pkg::P_MID_Q6) begin
         tag0.layer = palt_pkg::LAYER_LOWER;
      end else begin
         tag0.layer = palt_pkg::LAYER_UPPER;
      end
   end

   palt_log2 #(.ABITS(TABLE_ADDR_BITS)) u_log2 (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (tag0),
      .in_value (pres0_ff),
      .out_tag  (tag_l),
      .out_log  (log_l)
   );

   // Log ratio against the reference pressure of the chosen layer.
   always_comb begin
      case (tag_l.layer)
         palt_pkg::LAYER_TROPO: ref_sel = REF_SEA;
         palt_pkg::LAYER_LOWER: ref_sel = REF_TROPO;
         default:               ref_sel = REF_MID;
      endcase
      d_in = $signed({2'b00, log_l}) - ref_sel;
   end

   // The troposphere and upper layers scale by an exponent, the lower layer by metres.
   always_comb begin
      case (tagd_ff.layer)
         palt_pkg::LAYER_TROPO: coef_m = palt_pkg::EXP_TROPO_Q30;
         palt_pkg::LAYER_LOWER: coef_m = palt_pkg::K_LOWER_Q8;
         default:               coef_m = palt_pkg::EXP_UPPER_NEG_Q30;
      endcase
   end

   always_comb begin
      y = prodm_ff[59:30];
      if (y < Y_LO) begin
         yc = Y_LO;
      end else if (y > Y_HI) begin
         yc = Y_HI;
      end else begin
         yc = y;
      end
      argy_in = palt_pkg::ARG_W'(yc - Y_LO);
      round_m = prodm_ff + 60'sd8388608;
      h_lower = 36'(palt_pkg::BASE_LOWER_Q8) - round_m[59:24];
      tagy_in = tagm_ff;
      if (tagm_ff.layer == palt_pkg::LAYER_LOWER) tagy_in.alt = h_lower[26:0];
   end

   palt_exp2 #(.ABITS(TABLE_ADDR_BITS)) u_exp2 (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (tagy_ff),
      .in_arg  (argy_ff),
      .out_tag (tag_e),
      .out_pow (pow_e)
   );

   always_comb begin
      if (tag_e.layer == palt_pkg::LAYER_TROPO) begin
         t_in = ONE_T - $signed({1'b0, pow_e});
      end else begin
         t_in = $signed({1'b0, pow_e}) - ONE_T;
      end
      if (tags_ff.layer == palt_pkg::LAYER_TROPO) begin
         coef_k = palt_pkg::K_TROPO_Q8;
      end else begin
         coef_k = palt_pkg::K_UPPER_Q8;
      end
   end

   // Pressures above sea level give a negative troposphere altitude.
   always_comb begin
      round_k = prodk_ff + 57'sd8388608;
      case (tagk_ff.layer)
         palt_pkg::LAYER_TROPO: h_out = 34'($signed(round_k[56:24]));
         palt_pkg::LAYER_LOWER: h_out = 34'(tagk_ff.alt);
         default: h_out = 34'(palt_pkg::BASE_UPPER_Q8) + 34'($signed(round_k[56:24]));
      endcase
      if (h_out > 34'(palt_pkg::ALT_MAX)) begin
         alt_in = palt_pkg::ALT_MAX;
      end else if (h_out < 34'(palt_pkg::ALT_MIN)) begin
         alt_in = palt_pkg::ALT_MIN;
      end else begin
         alt_in = h_out[26:0];
      end
      if (tagk_ff.zero) alt_in = palt_pkg::ALT_MAX;
   end

   always_ff @(posedge clock) begin
      tagd_ff <= palt_pkg::gate_tag(tag_l, reset);
      d_ff <= d_in;

      tagm_ff <= palt_pkg::gate_tag(tagd_ff, reset);
      prodm_ff <= 60'(d_ff) * 60'(coef_m);

      tagy_ff <= palt_pkg::gate_tag(tagy_in, reset);
      argy_ff <= argy_in;

      tags_ff <= palt_pkg::gate_tag(tag_e, reset);
      t_ff <= t_in;

      tagk_ff <= palt_pkg::gate_tag(tags_ff, reset);
      prodk_ff <= 57'(t_ff) * 57'(coef_k);

      rsp_valid_ff <= tagk_ff.valid && !reset;
      rsp_altitude_ff <= alt_in;
      rsp_layer_ff <= tagk_ff.zero ? palt_pkg::LAYER_UPPER : tagk_ff.layer;
      rsp_saturated_ff <= tagk_ff.zero;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_altitude_q8 = rsp_altitude_ff;
   assign rsp_layer = rsp_layer_ff;
   assign rsp_saturated = rsp_saturated_ff;

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("request taken without a result after the pipeline latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching request");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_layer == palt_pkg::LAYER_UPPER && rsp_altitude_q8 == palt_pkg::ALT_MAX)
      else $error("saturated result with wrong layer or altitude");

   a_lower_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_layer == palt_pkg::LAYER_LOWER |->
         rsp_altitude_q8 >= palt_pkg::BASE_LOWER_Q8)
      else $error("lower stratosphere result below the tropopause");

endmodule

`default_nettype wire

>>> rtl/palt_log2.sv
// Four-stage log2 unit: normalize, table lookup, interpolation multiply, sum.
// Depends on palt_pkg for the tag type and the log table generator.
`default_nettype none

module palt_log2 #(
   parameter int ABITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  palt_pkg::tag_type             in_tag,
   input  logic [palt_pkg::PRES_W-1:0]   in_value,
   output palt_pkg::tag_type             out_tag,
   output logic [palt_pkg::LOG_W-1:0]    out_log
);

   localparam int N = 1 << ABITS;
   localparam int SH = 23 - ABITS;
   localparam int TW = palt_pkg::LOG_TAB_W;

   logic [TW-1:0] rom [0:N];

   for (genvar gi = 0; gi <= N; gi++) begin : g_rom
      localparam logic [TW-1:0] ENTRY = palt_pkg::log_entry(ABITS, gi);
      assign rom[gi] = ENTRY;
   end

   palt_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [4:0] k1_in, k1_ff, k2_ff, k3_ff;
   logic [palt_pkg::PRES_W-1:0] norm;
   logic [22:0] frac1_ff;
   logic [ABITS:0] idx_lo, idx_hi;
   logic [TW-1:0] lo2_ff, diff2_ff, lo3_ff, delta3_in, delta3_ff;
   logic [SH-1:0] r2_ff;
   logic [TW+SH-1:0] prod;
   logic [TW-1:0] mant;
   logic [palt_pkg::LOG_W-1:0] log4_in, log4_ff;

   // Position of the leading one; the value zero is handled by the caller.
   always_comb begin
      k1_in = 5'd0;
      for (int j = 0; j < palt_pkg::PRES_W; j++) begin
         if (in_value[j]) k1_in = 5'(j);
      end
      norm = in_value << (5'd23 - k1_in);
   end

   assign idx_lo = {1'b0, frac1_ff[22 -: ABITS]};
   assign idx_hi = idx_lo + 1'b1;
   assign prod = (TW + SH)'(diff2_ff) * (TW + SH)'(r2_ff);
   assign delta3_in = prod[SH +: TW];
   assign mant = lo3_ff + delta3_ff;
   assign log4_in = {k3_ff, 24'd0} + palt_pkg::LOG_W'(mant);

   always_ff @(posedge clock) begin
      tag1_ff <= palt_pkg::gate_tag(in_tag, reset);
      k1_ff <= k1_in;
      frac1_ff <= norm[22:0];

      tag2_ff <= palt_pkg::gate_tag(tag1_ff, reset);
      k2_ff <= k1_ff;
      lo2_ff <= rom[idx_lo];
      diff2_ff <= rom[idx_hi] - rom[idx_lo];
      r2_ff <= frac1_ff[SH-1:0];

      tag3_ff <= palt_pkg::gate_tag(tag2_ff, reset);
      k3_ff <= k2_ff;
      lo3_ff <= lo2_ff;
      delta3_ff <= delta3_in;

      tag4_ff <= palt_pkg::gate_tag(tag3_ff, reset);
      log4_ff <= log4_in;
   end

   assign out_tag = tag4_ff;
   assign out_log = log4_ff;

endmodule

`default_nettype wire

>>> rtl/palt_exp2.sv
// Three-stage exp2 unit: table lookup, interpolation multiply, sum and shift.
// Depends on palt_pkg for the tag type and the exp table generator.
`default_nettype none

module palt_exp2 #(
   parameter int ABITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  palt_pkg::tag_type             in_tag,
   input  logic [palt_pkg::ARG_W-1:0]    in_arg,
   output palt_pkg::tag_type             out_tag,
   output logic [palt_pkg::POW_W-1:0]    out_pow
);

   localparam int N = 1 << ABITS;
   localparam int SH = 24 - ABITS;
   localparam int TW = palt_pkg::EXP_TAB_W;

   logic [TW-1:0] rom [0:N];

   for (genvar gi = 0; gi <= N; gi++) begin : g_rom
      localparam logic [TW-1:0] ENTRY = palt_pkg::exp_entry(ABITS, gi);
      assign rom[gi] = ENTRY;
   end

   palt_pkg::tag_type tag1_ff, tag2_ff, tag3_ff;
   logic [ABITS:0] idx_lo, idx_hi;
   logic [TW-1:0] lo1_ff, diff1_ff, lo2_ff, delta2_ff;
   logic [SH-1:0] r1_ff;
   logic [2:0] n1_ff, n2_ff;
   logic [TW+SH-1:0] prod;
   logic [TW-1:0] mant;
   logic [palt_pkg::POW_W-1:0] pow3_in, pow3_ff;

   // The argument is offset by four, so its top three bits code the shift from -4 to 3.
   assign idx_lo = {1'b0, in_arg[23 -: ABITS]};
   assign idx_hi = idx_lo + 1'b1;
   assign prod = (TW + SH)'(diff1_ff) * (TW + SH)'(r1_ff);
   assign mant = lo2_ff + delta2_ff;

   always_comb begin
      if (n2_ff[2]) begin
         pow3_in = palt_pkg::POW_W'(mant) << n2_ff[1:0];
      end else begin
         pow3_in = palt_pkg::POW_W'(mant >> (3'd4 - n2_ff));
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= palt_pkg::gate_tag(in_tag, reset);
      lo1_ff <= rom[idx_lo];
      diff1_ff <= rom[idx_hi] - rom[idx_lo];
      r1_ff <= in_arg[SH-1:0];
      n1_ff <= in_arg[26:24];

      tag2_ff <= palt_pkg::gate_tag(tag1_ff, reset);
      lo2_ff <= lo1_ff;
      delta2_ff <= prod[SH +: TW];
      n2_ff <= n1_ff;

      tag3_ff <= palt_pkg::gate_tag(tag2_ff, reset);
      pow3_ff <= pow3_in;
   end

   assign out_tag = tag3_ff;
   assign out_pow = pow3_ff;

endmodule

`default_nettype wire
